// ===== src/superio_config_register_space_assert.svh =====
// assertion macros shared by the checker of the super i/o configuration block
// every macro samples on clk and is switched off while rst_n is low
`ifndef SUPERIO_CONFIG_REGISTER_SPACE_ASSERT_SVH
`define SUPERIO_CONFIG_REGISTER_SPACE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SCFG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfg assertion failed");

// antecedent implies consequent in the next cycle
`define SCFG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfg assertion failed");

// antecedent implies a later consequent
`define SCFG_ASSERT_TWO(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("scfg assertion failed");

`endif

// ===== src/scfg_pkg.sv =====
// shared types, constants and base-address helpers of the super i/o configuration block
// no dependencies; used by every module of the block
package scfg_pkg;

    localparam int NUM_REGS_DEF = 42;

    // index port keys and the write-protect boundary
    localparam logic [7:0] KEY_ENTER = 8'h55;
    localparam logic [7:0] KEY_EXIT  = 8'hAA;
    localparam logic [7:0] WP_LIMIT  = 8'h18;

    // register indices with side effects or protection
    localparam logic [7:0] REG_CR0    = 8'h00;
    localparam logic [7:0] REG_CR1    = 8'h01;
    localparam logic [7:0] REG_CR2    = 8'h02;
    localparam logic [7:0] REG_CR3    = 8'h03;
    localparam logic [7:0] REG_CR6    = 8'h06;
    localparam logic [7:0] REG_CRD    = 8'h0D;
    localparam logic [7:0] REG_CRE    = 8'h0E;
    localparam logic [7:0] REG_CR1E   = 8'h1E;
    localparam logic [7:0] REG_FDC    = 8'h20;
    localparam logic [7:0] REG_IDE    = 8'h21;
    localparam logic [7:0] REG_IDEALT = 8'h22;
    localparam logic [7:0] REG_PAR    = 8'h23;
    localparam logic [7:0] REG_SER1   = 8'h24;
    localparam logic [7:0] REG_SER2   = 8'h25;
    localparam logic [7:0] REG_RO0    = 8'h26;
    localparam logic [7:0] REG_RO1    = 8'h27;
    localparam logic [7:0] REG_IRQ    = 8'h28;
    localparam logic [7:0] REG_RO2    = 8'h29;

    // reset values of the side-effect registers
    localparam logic [7:0] DEF_CR0    = 8'h28;
    localparam logic [7:0] DEF_CR1    = 8'h9C;
    localparam logic [7:0] DEF_CR2    = 8'h88;
    localparam logic [7:0] DEF_FDC    = 8'hFC;
    localparam logic [7:0] DEF_IDE    = 8'h7C;
    localparam logic [7:0] DEF_IDEALT = 8'hFD;
    localparam logic [7:0] DEF_PAR    = 8'hDE;
    localparam logic [7:0] DEF_SER1   = 8'hFE;
    localparam logic [7:0] DEF_SER2   = 8'hBE;
    localparam logic [7:0] DEF_IRQ    = 8'h43;

    // legal i/o ports; the first of each list is its default, but serial 2 defaults to SER_PORT1
    localparam logic [9:0] FDC_PORT0    = 10'h3F0;
    localparam logic [9:0] FDC_PORT1    = 10'h370;
    localparam logic [9:0] IDE_PORT0    = 10'h1F0;
    localparam logic [9:0] IDE_PORT1    = 10'h170;
    localparam logic [9:0] IDEALT_PORT0 = 10'h3F6;
    localparam logic [9:0] IDEALT_PORT1 = 10'h376;
    localparam logic [9:0] PAR_PORT0    = 10'h378;
    localparam logic [9:0] PAR_PORT1    = 10'h3BC;
    localparam logic [9:0] PAR_PORT2    = 10'h278;
    localparam logic [9:0] SER_PORT0    = 10'h3F8;
    localparam logic [9:0] SER_PORT1    = 10'h2F8;
    localparam logic [9:0] SER_PORT2    = 10'h338;
    localparam logic [9:0] SER_PORT3    = 10'h3E8;
    localparam logic [9:0] SER_PORT4    = 10'h2E8;
    localparam logic [9:0] SER_PORT5    = 10'h220;
    localparam logic [9:0] SER_PORT6    = 10'h238;
    localparam logic [9:0] SER_PORT7    = 10'h2E0;
    localparam logic [9:0] SER_PORT8    = 10'h228;

    localparam logic [7:0] MASK_W6 = 8'hFC;
    localparam logic [7:0] MASK_W7 = 8'hFE;
    localparam logic [7:0] MASK_W8 = 8'hFF;

    // configuration key sequencer
    typedef enum logic [1:0] {
        CFG_LOCKED,
        CFG_ARMED,
        CFG_OPEN
    } cfg_state_t;

    // register write request towards the side-effect registers
    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        logic [7:0] data;
    } wr_req_t;

    // read response of the side-effect registers
    typedef struct packed {
        logic       hit;
        logic [7:0] data;
    } spec_rd_t;

    // reset value of a plain storage entry
    function automatic logic [7:0] reg_default(input logic [7:0] idx);
        logic [7:0] val;
        case (idx)
            REG_CR3:  val = 8'h78;
            REG_CR6:  val = 8'hFF;
            REG_CRD:  val = 8'h03;
            REG_CRE:  val = 8'h02;
            REG_CR1E: val = 8'h80;
            REG_RO0:  val = 8'h23;
            REG_RO1:  val = 8'h67;
            default:  val = 8'h00;
        endcase
        return val;
    endfunction

    // i/o port given by the address bits of a base register
    function automatic logic [9:0] port_of(input logic [7:0] r, input logic [7:0] mask);
        return {r & mask, 2'b00};
    endfunction

    // keep the register if its port is legal, otherwise load the default port
    function automatic logic [7:0] rebase(input logic [7:0] r, input logic [7:0] mask,
                                          input logic ok, input logic [9:0] dflt);
        return ok ? r : ((dflt[9:2] & mask) | (r & ~mask));
    endfunction

    function automatic logic [7:0] fix_fdc(input logic [7:0] r);
        logic [9:0] p;
        p = port_of(r, MASK_W6);
        return rebase(r, MASK_W6, (p == FDC_PORT0) || (p == FDC_PORT1), FDC_PORT0);
    endfunction

    function automatic logic [7:0] fix_ide(input logic [7:0] r);
        logic [9:0] p;
        p = port_of(r, MASK_W6);
        return rebase(r, MASK_W6, (p == IDE_PORT0) || (p == IDE_PORT1), IDE_PORT0);
    endfunction

    // the alternate ide ports have low bits set, so they never match
    function automatic logic [7:0] fix_idealt(input logic [7:0] r);
        logic [9:0] p;
        p = port_of(r, MASK_W6);
        return rebase(r, MASK_W6, (p == IDEALT_PORT0) || (p == IDEALT_PORT1), IDEALT_PORT0);
    endfunction

    function automatic logic [7:0] fix_par(input logic [7:0] r);
        logic [9:0] p;
        p = port_of(r, MASK_W8);
        return rebase(r, MASK_W8,
                      (p == PAR_PORT0) || (p == PAR_PORT1) || (p == PAR_PORT2), PAR_PORT0);
    endfunction

    function automatic logic [7:0] fix_ser(input logic [7:0] r, input logic [9:0] dflt);
        logic [9:0] p;
        logic       ok;
        p  = port_of(r, MASK_W7);
        ok = (p == SER_PORT0) || (p == SER_PORT1) || (p == SER_PORT2) ||
             (p == SER_PORT3) || (p == SER_PORT4) || (p == SER_PORT5) ||
             (p == SER_PORT6) || (p == SER_PORT7) || (p == SER_PORT8);
        return rebase(r, MASK_W7, ok, dflt);
    endfunction

endpackage

// ===== src/scfg_mem.sv =====
// plain storage of the configuration registers, one write and one registered read per cycle
// depends on scfg_pkg for the entry reset values
module scfg_mem #(
    parameter int NUM_REGS = scfg_pkg::NUM_REGS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [$clog2(NUM_REGS)-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic [$clog2(NUM_REGS)-1:0] raddr,
    output logic [7:0]                  rdata
);

    localparam int IDX_W = $clog2(NUM_REGS);

    logic [7:0]          mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [7:0]          rd_data_reg;
    logic [IDX_W-1:0]    rd_addr_reg;

    // array write and registered read, new data forwarded on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rd_data_reg <= wdata;
        end
        else
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_addr_reg <= raddr;
        end
    end

    // an unwritten entry reads as its reset value
    assign rdata = valid_reg[rd_addr_reg] ? rd_data_reg
                                          : scfg_pkg::reg_default(8'(rd_addr_reg));

endmodule

// ===== src/scfg_special.sv =====
// registers with side effects: device control, base addresses, irq select, write-protect
// depends on scfg_pkg for indices, reset values and base-address revalidation
module scfg_special (
    input  logic               clk,
    input  logic               rst_n,
    input  scfg_pkg::wr_req_t  wr,
    input  logic [7:0]         rd_idx,
    output scfg_pkg::spec_rd_t rd,
    output logic               write_protect
);

    logic [7:0] cr0_reg, cr0_next;
    logic [7:0] cr1_reg, cr1_next;
    logic [7:0] cr2_reg, cr2_next;
    logic [7:0] fdc_reg, fdc_next;
    logic [7:0] ide_reg, ide_next;
    logic [7:0] idealt_reg, idealt_next;
    logic [7:0] par_reg, par_next;
    logic [7:0] ser1_reg, ser1_next;
    logic [7:0] ser2_reg, ser2_next;
    logic [7:0] irq_reg, irq_next;
    logic       wp_reg, wp_next;

    // store of one data byte and the revalidations it triggers
    always_comb
    begin
        logic [7:0] x;
        logic [7:0] t;
        cr0_next    = cr0_reg;
        cr1_next    = cr1_reg;
        cr2_next    = cr2_reg;
        fdc_next    = fdc_reg;
        ide_next    = ide_reg;
        idealt_next = idealt_reg;
        par_next    = par_reg;
        ser1_next   = ser1_reg;
        ser2_next   = ser2_reg;
        irq_next    = irq_reg;
        wp_next     = wp_reg;
        x           = 8'h00;
        t           = wr.data;
        if (wr.en)
        begin
            case (wr.idx)
                scfg_pkg::REG_CR0:
                begin
                    x        = wr.data ^ cr0_reg;
                    cr0_next = wr.data;
                    if ((x[1:0] == 2'b00) && x[3] && wr.data[3] && (fdc_reg[7:6] != 2'b00))
                    begin
                        fdc_next = scfg_pkg::fix_fdc(fdc_reg);
                    end
                end
                scfg_pkg::REG_CR1:
                begin
                    x        = wr.data ^ cr1_reg;
                    cr1_next = wr.data;
                    if (x[2] && wr.data[2] && (par_reg[7:6] != 2'b00))
                    begin
                        par_next = scfg_pkg::fix_par(par_reg);
                    end
                    if (x[2:0] != 3'b000)
                    begin
                        wp_next = !wr.data[3];
                    end
                end
                scfg_pkg::REG_CR2:
                begin
                    x        = wr.data ^ cr2_reg;
                    cr2_next = wr.data;
                    if (x[3] && wr.data[3] && (ser1_reg[7:6] != 2'b00))
                    begin
                        ser1_next = scfg_pkg::fix_ser(ser1_reg, scfg_pkg::SER_PORT0);
                    end
                    if (x[7] && wr.data[7] && (ser2_reg[7:6] != 2'b00))
                    begin
                        ser2_next = scfg_pkg::fix_ser(ser2_reg, scfg_pkg::SER_PORT1);
                    end
                end
                scfg_pkg::REG_FDC:
                begin
                    x        = wr.data ^ fdc_reg;
                    fdc_next = wr.data;
                    if ((x[7:2] != 6'd0) && cr0_reg[3] && (wr.data[7:6] != 2'b00))
                    begin
                        fdc_next = scfg_pkg::fix_fdc(wr.data);
                    end
                end
                scfg_pkg::REG_IDE:
                begin
                    x        = wr.data ^ ide_reg;
                    ide_next = (x[7:2] != 6'd0) ? scfg_pkg::fix_ide(wr.data) : wr.data;
                end
                scfg_pkg::REG_IDEALT:
                begin
                    x           = wr.data ^ idealt_reg;
                    idealt_next = (x[7:2] != 6'd0) ? scfg_pkg::fix_idealt(wr.data) : wr.data;
                end
                scfg_pkg::REG_PAR:
                begin
                    x        = wr.data ^ par_reg;
                    par_next = wr.data;
                    if ((x != 8'h00) && cr1_reg[2] && (wr.data[7:6] != 2'b00))
                    begin
                        par_next = scfg_pkg::fix_par(wr.data);
                    end
                end
                scfg_pkg::REG_SER1:
                begin
                    x         = wr.data ^ ser1_reg;
                    ser1_next = wr.data;
                    if ((x[7:1] != 7'd0) && cr2_reg[3] && (wr.data[7:6] != 2'b00))
                    begin
                        ser1_next = scfg_pkg::fix_ser(wr.data, scfg_pkg::SER_PORT0);
                    end
                end
                scfg_pkg::REG_SER2:
                begin
                    x         = wr.data ^ ser2_reg;
                    ser2_next = wr.data;
                    if ((x[7:1] != 7'd0) && cr2_reg[7] && (wr.data[7:6] != 2'b00))
                    begin
                        ser2_next = scfg_pkg::fix_ser(wr.data, scfg_pkg::SER_PORT1);
                    end
                end
                scfg_pkg::REG_IRQ:
                begin
                    x = wr.data ^ irq_reg;
                    // a cleared nibble falls back to its default irq
                    if (x[3:0] != 4'h0)
                    begin
                        if (t[3:0] == 4'h0)
                        begin
                            t[3:0] = 4'h3;
                        end
                        if (cr2_reg[7] && (ser2_reg[7:6] != 2'b00))
                        begin
                            ser2_next = scfg_pkg::fix_ser(ser2_reg, scfg_pkg::SER_PORT1);
                        end
                    end
                    if (x[7:4] != 4'h0)
                    begin
                        if (t[7:4] == 4'h0)
                        begin
                            t[7:4] = 4'h4;
                        end
                        if (cr2_reg[3] && (ser1_reg[7:6] != 2'b00))
                        begin
                            ser1_next = scfg_pkg::fix_ser(ser1_reg, scfg_pkg::SER_PORT0);
                        end
                    end
                    irq_next = t;
                end
                default:
                begin
                end
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr0_reg    <= scfg_pkg::DEF_CR0;
            cr1_reg    <= scfg_pkg::DEF_CR1;
            cr2_reg    <= scfg_pkg::DEF_CR2;
            fdc_reg    <= scfg_pkg::DEF_FDC;
            ide_reg    <= scfg_pkg::DEF_IDE;
            idealt_reg <= scfg_pkg::DEF_IDEALT;
            par_reg    <= scfg_pkg::DEF_PAR;
            ser1_reg   <= scfg_pkg::DEF_SER1;
            ser2_reg   <= scfg_pkg::DEF_SER2;
            irq_reg    <= scfg_pkg::DEF_IRQ;
            wp_reg     <= 1'b0;
        end
        else
        begin
            cr0_reg    <= cr0_next;
            cr1_reg    <= cr1_next;
            cr2_reg    <= cr2_next;
            fdc_reg    <= fdc_next;
            ide_reg    <= ide_next;
            idealt_reg <= idealt_next;
            par_reg    <= par_next;
            ser1_reg   <= ser1_next;
            ser2_reg   <= ser2_next;
            irq_reg    <= irq_next;
            wp_reg     <= wp_next;
        end
    end

    // read select for the currently indexed register
    always_comb
    begin
        rd.hit = 1'b1;
        case (rd_idx)
            scfg_pkg::REG_CR0:    rd.data = cr0_reg;
            scfg_pkg::REG_CR1:    rd.data = cr1_reg;
            scfg_pkg::REG_CR2:    rd.data = cr2_reg;
            scfg_pkg::REG_FDC:    rd.data = fdc_reg;
            scfg_pkg::REG_IDE:    rd.data = ide_reg;
            scfg_pkg::REG_IDEALT: rd.data = idealt_reg;
            scfg_pkg::REG_PAR:    rd.data = par_reg;
            scfg_pkg::REG_SER1:   rd.data = ser1_reg;
            scfg_pkg::REG_SER2:   rd.data = ser2_reg;
            scfg_pkg::REG_IRQ:    rd.data = irq_reg;
            default:
            begin
                rd.hit  = 1'b0;
                rd.data = 8'h00;
            end
        endcase
    end

    assign write_protect = wp_reg;

endmodule

// ===== src/superio_config_register_space.sv =====
// Super I/O configuration space reached through an index port and a data port. Each item is
// one host access; the block takes one item per clock cycle for as long as results are taken.
// An accepted item is held in the input register, then the key sequencer, index, register
// update and read select settle into the result register. The plain register storage is read
// ahead at the index being selected, so its registered read port sets no extra delay. Storage
// comes out of reset ready, with no clearing pass. Reads outside configuration mode return
// 0xFF and writes return 0.
// depends on scfg_pkg, scfg_mem and scfg_special
module superio_config_register_space #(
    parameter int NUM_REGS = scfg_pkg::NUM_REGS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic       port_select,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    localparam int IDX_W = $clog2(NUM_REGS);

    logic                 in_valid_reg;
    logic                 func_reg;
    logic                 port_reg;
    logic [7:0]           wdata_reg;
    logic                 out_valid_reg;
    logic [7:0]           read_data_reg;
    logic [7:0]           read_data_next;
    logic [IDX_W-1:0]     sel_reg, sel_next;
    scfg_pkg::cfg_state_t state_reg, state_next;
    logic                 config_mode;
    logic                 advance;
    logic                 proc;
    logic                 index_wr;
    logic                 wp;
    logic                 prot;
    logic [7:0]           sel8;
    logic [7:0]           mem_rdata;
    scfg_pkg::wr_req_t    wr_req;
    scfg_pkg::spec_rd_t   spec_rd;

    // handshake: the input register moves on whenever the result slot is free or draining
    assign advance  = !out_valid_reg || out_ready;
    assign proc     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign index_wr = proc && func_reg && !port_reg;
    assign sel8     = 8'(sel_reg);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= func;
            port_reg  <= port_select;
            wdata_reg <= write_data;
        end
    end

    // key sequencer next state
    always_comb
    begin
        state_next = state_reg;
        if (index_wr)
        begin
            case (state_reg)
                scfg_pkg::CFG_LOCKED:
                    state_next = (wdata_reg == scfg_pkg::KEY_ENTER) ? scfg_pkg::CFG_ARMED
                                                                    : scfg_pkg::CFG_LOCKED;
                scfg_pkg::CFG_ARMED:
                    state_next = (wdata_reg == scfg_pkg::KEY_ENTER) ? scfg_pkg::CFG_OPEN
                                                                    : scfg_pkg::CFG_LOCKED;
                scfg_pkg::CFG_OPEN:
                    state_next = (wdata_reg == scfg_pkg::KEY_EXIT) ? scfg_pkg::CFG_LOCKED
                                                                   : scfg_pkg::CFG_OPEN;
                default:
                    state_next = scfg_pkg::CFG_LOCKED;
            endcase
        end
    end

    // key sequencer outputs
    always_comb
    begin
        case (state_reg)
            scfg_pkg::CFG_OPEN: config_mode = 1'b1;
            default:            config_mode = 1'b0;
        endcase
    end

    // register selection by index writes in configuration mode, for indices below NUM_REGS
    always_comb
    begin
        sel_next = sel_reg;
        if (index_wr && config_mode && (wdata_reg < 8'(NUM_REGS)))
        begin
            sel_next = wdata_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scfg_pkg::CFG_LOCKED;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // data writes, dropped for protected indices
    assign prot = ((sel8 < scfg_pkg::WP_LIMIT) && wp) || (sel8 == scfg_pkg::REG_RO0) ||
                  (sel8 == scfg_pkg::REG_RO1) || (sel8 == scfg_pkg::REG_RO2);

    always_comb
    begin
        wr_req.en   = proc && func_reg && port_reg && config_mode && !prot;
        wr_req.idx  = sel8;
        wr_req.data = wdata_reg;
    end

    scfg_special u_special (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr_req),
        .rd_idx        (sel8),
        .rd            (spec_rd),
        .write_protect (wp)
    );

    scfg_mem #(
        .NUM_REGS (NUM_REGS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (wr_req.en),
        .waddr (sel_reg),
        .wdata (wdata_reg),
        .raddr (sel_next),
        .rdata (mem_rdata)
    );

    // read result
    always_comb
    begin
        if (func_reg)
        begin
            read_data_next = 8'h00;
        end
        else if (!config_mode)
        begin
            read_data_next = 8'hFF;
        end
        else if (!port_reg)
        begin
            read_data_next = sel8;
        end
        else if ((sel8 < scfg_pkg::WP_LIMIT) && wp)
        begin
            read_data_next = 8'hFF;
        end
        else
        begin
            read_data_next = spec_rd.hit ? spec_rd.data : mem_rdata;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            read_data_reg <= read_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

// ===== src/scfg_checker.sv =====
// port-level checks of the super i/o configuration block, bound to its top level
// depends on superio_config_register_space_assert.svh for the assertion macros
`include "superio_config_register_space_assert.svh"

module scfg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data
);

    // a result not yet taken holds its byte
    `SCFG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data))

    // input only stalls behind a full, blocked result slot
    `SCFG_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready)

    // every accepted item finds a result on show once it has passed the input and result registers
    `SCFG_ASSERT_TWO(a_result_due, in_valid && in_ready, out_valid)

endmodule

bind superio_config_register_space scfg_checker u_scfg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data)
);
